[hw/rtl/fba_pkg.sv]
// ----------------------------------------------------------------------------
// fba_pkg
// shared types and constants of the fixed block allocator
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_HEADER_BYTES = 8;
  localparam int POOL_HEADER      = 8;

  localparam int APB_ADDR_W = 4;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  localparam logic [31:0] RST_BASE  = 32'd0;
  localparam logic [16:0] RST_SIZE  = 17'd64;
  localparam logic [6:0]  RST_COUNT = 7'd64;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;
  localparam logic [1:0] ST_DOUBLE = 2'd3;

  typedef struct packed {
    logic [31:0] base_address;
    logic [16:0] block_size;
    logic [6:0]  block_count;
  } cfg_t;

endpackage

[hw/rtl/fba_if.sv]
// ----------------------------------------------------------------------------
// fba_if
// request and response channels of the fixed block allocator
// ----------------------------------------------------------------------------
interface fba_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] block_address;

  modport source (output valid, action, block_address, input ready);
  modport sink   (input valid, action, block_address, output ready);
endinterface

interface fba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic [1:0]  status;
  logic [6:0]  free_blocks;

  modport source (output valid, granted_address, status, free_blocks, input ready);
  modport sink   (input valid, granted_address, status, free_blocks, output ready);
endinterface

[hw/rtl/fba_cfg.sv]
// ----------------------------------------------------------------------------
// fba_cfg
// apb register file: pool base, block size, block count
// ----------------------------------------------------------------------------
module fba_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fba_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output fba_pkg::cfg_t                    cfg
);
  import fba_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= RST_BASE;
      cfg.block_size   <= RST_SIZE;
      cfg.block_count  <= RST_COUNT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE:  cfg.base_address <= pwdata;
        REG_SIZE:  cfg.block_size   <= pwdata[16:0];
        REG_COUNT: cfg.block_count  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE:  prdata = cfg.base_address;
      REG_SIZE:  prdata = {15'd0, cfg.block_size};
      REG_COUNT: prdata = {25'd0, cfg.block_count};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

[hw/rtl/fba_seq.sv]
// ----------------------------------------------------------------------------
// fba_seq
// scan sequencer: walks the block free map with one running address adder
// ----------------------------------------------------------------------------
module fba_seq #(
  parameter int MAX_BLOCKS   = fba_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = fba_pkg::DEF_HEADER_BYTES
) (
  input  logic          clk,
  input  logic          rst,
  input  fba_pkg::cfg_t cfg,
  fba_req_if.sink       req,
  fba_rsp_if.source     rsp
);
  import fba_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_DONE} state_t;

  state_t             state;
  logic [IDX_W-1:0]   clr_idx;
  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   cur_idx;
  logic [31:0]        cur_addr;
  logic [31:0]        stride;
  logic               act;
  logic [31:0]        in_addr;
  logic               found;
  logic [CNT_W-1:0]   count;
  logic [31:0]        granted;
  logic [1:0]         st;
  logic               s_vld;
  logic [IDX_W-1:0]   s_idx;
  logic [31:0]        s_addr;

  logic               free_map [MAX_BLOCKS];
  logic               rd_data;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic               mem_wd;
  logic [IDX_W-1:0]   mem_ra;

  logic               hit;
  logic               post;
  logic [CNT_W-1:0]   lim_next;
  logic               issue;

  logic               o_vld;
  logic [31:0]        o_granted;
  logic [1:0]         o_status;
  logic [CNT_W-1:0]   o_free;

  assign stride = 32'(HEADER_BYTES)
                + ((32'(cfg.block_size) + 32'd3) & ~32'd3);

  assign lim_next = (32'(cfg.block_count) > 32'(MAX_BLOCKS)) ?
                    CNT_W'(MAX_BLOCKS) : CNT_W'(cfg.block_count);

  assign issue  = (state == S_SCAN) && (cur_idx < lim);
  assign mem_ra = cur_idx[IDX_W-1:0];

  always_comb begin
    hit = 1'b0;
    if (s_vld && !found) begin
      if (act == ACT_ALLOC) begin
        hit = rd_data;
      end else begin
        hit = (s_addr == in_addr);
      end
    end
    post = hit ? (act == ACT_FREE) : rd_data;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = s_idx;
    mem_wd = post;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_idx;
      mem_wd = 1'b1;
    end else if (hit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      free_map[mem_wa] <= mem_wd;
    end
    rd_data <= free_map[mem_ra];
  end

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = o_vld;
  assign rsp.granted_address = o_granted;
  assign rsp.status          = o_status;
  assign rsp.free_blocks     = 7'(32'(o_free));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      s_vld   <= 1'b0;
      o_vld   <= 1'b0;
      found   <= 1'b0;
    end else begin
      if (o_vld && rsp.ready && state != S_DONE) begin
        o_vld <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(MAX_BLOCKS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            act      <= req.action;
            in_addr  <= req.block_address;
            lim      <= lim_next;
            cur_idx  <= '0;
            cur_addr <= cfg.base_address + 32'(POOL_HEADER) + 32'(HEADER_BYTES);
            found    <= 1'b0;
            count    <= '0;
            granted  <= 32'd0;
            st       <= (req.action == ACT_ALLOC) ? ST_NONE : ST_BAD;
            s_vld    <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          s_vld <= issue;
          if (issue) begin
            s_idx    <= cur_idx[IDX_W-1:0];
            s_addr   <= cur_addr;
            cur_idx  <= cur_idx + 1'b1;
            cur_addr <= cur_addr + stride;
          end
          if (s_vld) begin
            count <= count + CNT_W'(post);
          end
          if (hit) begin
            found <= 1'b1;
            if (act == ACT_ALLOC) begin
              granted <= s_addr;
              st      <= ST_OK;
            end else begin
              st <= rd_data ? ST_DOUBLE : ST_OK;
            end
          end
          if (!issue && !s_vld) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!o_vld || rsp.ready) begin
            o_vld     <= 1'b1;
            o_granted <= granted;
            o_status  <= st;
            o_free    <= count;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cur_idx <= lim))
    else $error("scan index ran past the block limit");

  a_write_src: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != S_CLEAR) |-> (s_vld && !found))
    else $error("free map written outside a first match");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (o_vld && (o_status == ST_NONE || o_status == ST_BAD ||
               o_status == ST_DOUBLE)) |-> (o_granted == 32'd0))
    else $error("failed request returned an address");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    $rose(o_vld) |-> (o_free <= lim))
    else $error("free count exceeds the active block count");

endmodule

[hw/rtl/fixed_block_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_block_allocator
// pool allocator for equal-size blocks with an apb configuration port
// ----------------------------------------------------------------------------
// req channel: action (0 allocate, 1 free) and block_address, one item per
//   handshake; rsp channel: granted_address, status and free_blocks, one
//   item for each request.
// apb registers: base_address at 0x0, block_size at 0x4, block_count at
//   0x8; write them only while no request is in flight.
// after rst the free map is swept to all free with req.ready low; apb
//   writes are taken meanwhile.
// each request walks the free map one block a cycle with a single running
//   address adder and comparator, over block_count blocks capped at
//   MAX_BLOCKS; a new request is taken only once the response of the last
//   has been registered.
// req.ready is high only between requests. the response sits in an output
//   register; if rsp.ready is low the next request can still be accepted
//   and scanned, and its response waits until the register is taken.
// ----------------------------------------------------------------------------
module fixed_block_allocator #(
  parameter int MAX_BLOCKS   = fba_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = fba_pkg::DEF_HEADER_BYTES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fba_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  fba_req_if.sink                        req,
  fba_rsp_if.source                      rsp
);
  import fba_pkg::*;

  cfg_t cfg;

  fba_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fba_seq #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_seq (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

endmodule
